// File: hw/rtl/best_fit_gap_select_defines.svh
// assertion macros for the gap selector
`ifndef BEST_FIT_GAP_SELECT_DEFINES_SVH
`define BEST_FIT_GAP_SELECT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define BFGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define BFGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFGS_ASSERT(lbl, prop, msg)
`define BFGS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/bfgs_pkg.sv
// shared types and constants for the gap selector
package bfgs_pkg;

  localparam int FIELD_W = 32;
  localparam int DIST_W  = 34;
  localparam int INDEX_W = 5;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [1:0]        rule_t;
  typedef logic [1:0]        tally_t;

  // 99999 in 16.16
  localparam dist_t DIST_START = 34'd6553534464;

  localparam rule_t RULE_CONTAIN   = 2'd0;
  localparam rule_t RULE_ONLY_FIT  = 2'd1;
  localparam rule_t RULE_BEST_FIT  = 2'd2;
  localparam rule_t RULE_BEST_MISS = 2'd3;

  localparam tally_t TALLY_NONE = 2'd0;
  localparam tally_t TALLY_ONE  = 2'd1;
  localparam tally_t TALLY_MANY = 2'd2;

  typedef struct packed {
    logic  contains;
    logic  fits;
    dist_t foot_dist;
  } gap_eval_t;

endpackage

// File: hw/rtl/bfgs_gap_eval.sv
// per-gap tests: containment, fit and foot distance
module bfgs_gap_eval (
  input  logic signed [bfgs_pkg::FIELD_W-1:0] gap_bottom,
  input  logic signed [bfgs_pkg::FIELD_W-1:0] gap_top,
  input  logic signed [bfgs_pkg::FIELD_W-1:0] foot_z,
  input  logic signed [bfgs_pkg::FIELD_W-1:0] head_z,
  output bfgs_pkg::gap_eval_t                 eval
);

  logic signed [bfgs_pkg::DIST_W-1:0] f_x;
  logic signed [bfgs_pkg::DIST_W-1:0] c_x;
  logic signed [bfgs_pkg::DIST_W-1:0] z1_x;
  logic signed [bfgs_pkg::DIST_W-1:0] z2_x;
  logic signed [bfgs_pkg::DIST_W-1:0] foot_off;
  logic signed [bfgs_pkg::DIST_W-1:0] span;
  logic signed [bfgs_pkg::DIST_W-1:0] room;

  assign f_x  = bfgs_pkg::DIST_W'(gap_bottom);
  assign c_x  = bfgs_pkg::DIST_W'(gap_top);
  assign z1_x = bfgs_pkg::DIST_W'(foot_z);
  assign z2_x = bfgs_pkg::DIST_W'(head_z);

  // differences are exact at 34 bits
  assign foot_off = z1_x - f_x;
  assign span     = z2_x - z1_x;
  assign room     = c_x - f_x;

  always_comb begin
    eval.contains = (foot_z >= gap_bottom) && (head_z <= gap_top);
    eval.fits     = (span <= room);
    if (foot_off[bfgs_pkg::DIST_W-1]) begin
      eval.foot_dist = bfgs_pkg::dist_t'(-foot_off);
    end else begin
      eval.foot_dist = bfgs_pkg::dist_t'(foot_off);
    end
  end

endmodule

// File: hw/rtl/best_fit_gap_select.sv
// gap selector: the last gap's beat passes the input, test and result registers
// (input register, test register, result register) before its result appears;
// it waits in the test register while a held result is stalled; throughput one
// gap per cycle while in_stall is low, bounded by the running-minimum update register
// rst (synchronous) empties all stages and clears the list state
`include "best_fit_gap_select_defines.svh"

module best_fit_gap_select #(
  parameter int MAX_GAPS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bfgs_pkg::FIELD_W-1:0] gap_bottom,
  input  logic signed [bfgs_pkg::FIELD_W-1:0] gap_top,
  input  logic signed [bfgs_pkg::FIELD_W-1:0] foot_z,
  input  logic signed [bfgs_pkg::FIELD_W-1:0] head_z,
  input  logic                                last_gap,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bfgs_pkg::INDEX_W-1:0]        chosen_index,
  output logic                                chosen_valid,
  output bfgs_pkg::rule_t                     choice_rule
);

  localparam int POS_W = $clog2(MAX_GAPS);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_GAPS - 1);

  // input stage
  logic                                a_v;
  logic signed [bfgs_pkg::FIELD_W-1:0] a_bottom;
  logic signed [bfgs_pkg::FIELD_W-1:0] a_top;
  logic signed [bfgs_pkg::FIELD_W-1:0] a_foot;
  logic signed [bfgs_pkg::FIELD_W-1:0] a_head;
  logic                                a_last;
  bfgs_pkg::gap_eval_t                 a_eval;

  // test stage
  logic                b_v;
  logic                b_last;
  bfgs_pkg::gap_eval_t b_eval;

  // handshake
  logic out_free;
  logic b_go;
  logic b_free;
  logic a_free;
  logic in_take;

  // list state
  logic [POS_W-1:0]     gap_position;
  logic                 contain_found;
  logic [POS_W-1:0]     contain_index;
  bfgs_pkg::tally_t     fit_tally;
  logic [POS_W-1:0]     fit_recent_index;
  logic [POS_W-1:0]     fit_best_index;
  bfgs_pkg::dist_t      fit_best_distance;
  logic                 fit_hit;
  logic [POS_W-1:0]     nofit_best_index;
  bfgs_pkg::dist_t      nofit_best_distance;
  logic                 nofit_found;

  logic                 contain_found_next;
  logic [POS_W-1:0]     contain_index_next;
  bfgs_pkg::tally_t     fit_tally_next;
  logic [POS_W-1:0]     fit_recent_index_next;
  logic [POS_W-1:0]     fit_best_index_next;
  bfgs_pkg::dist_t      fit_best_distance_next;
  logic                 fit_hit_next;
  logic [POS_W-1:0]     nofit_best_index_next;
  bfgs_pkg::dist_t      nofit_best_distance_next;
  logic                 nofit_found_next;

  logic                 res_valid;
  logic [POS_W-1:0]     res_idx;
  bfgs_pkg::rule_t      res_rule;
  logic [POS_W+4:0]     idx_ext;

  assign out_free = !out_valid || !out_stall;
  assign b_go     = b_v && (!b_last || out_free);
  assign b_free   = !b_v || b_go;
  assign a_free   = !a_v || b_free;
  assign in_stall = !a_free;
  assign in_take  = in_valid && a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_free) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_bottom <= gap_bottom;
      a_top    <= gap_top;
      a_foot   <= foot_z;
      a_head   <= head_z;
      a_last   <= last_gap;
    end
  end

  bfgs_gap_eval u_eval (
    .gap_bottom (a_bottom),
    .gap_top    (a_top),
    .foot_z     (a_foot),
    .head_z     (a_head),
    .eval       (a_eval)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_free) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_v) begin
      b_eval <= a_eval;
      b_last <= a_last;
    end
  end

  // fold this gap into the running choice
  always_comb begin
    contain_found_next       = contain_found;
    contain_index_next       = contain_index;
    fit_tally_next           = fit_tally;
    fit_recent_index_next    = fit_recent_index;
    fit_best_index_next      = fit_best_index;
    fit_best_distance_next   = fit_best_distance;
    fit_hit_next             = fit_hit;
    nofit_best_index_next    = nofit_best_index;
    nofit_best_distance_next = nofit_best_distance;
    nofit_found_next         = nofit_found;
    if (!contain_found) begin
      if (b_eval.contains) begin
        contain_found_next = 1'b1;
        contain_index_next = gap_position;
      end else if (b_eval.fits) begin
        if (fit_tally != bfgs_pkg::TALLY_MANY) begin
          fit_tally_next = fit_tally + bfgs_pkg::TALLY_ONE;
        end
        fit_recent_index_next = gap_position;
        if (b_eval.foot_dist < fit_best_distance) begin
          fit_best_distance_next = b_eval.foot_dist;
          fit_best_index_next    = gap_position;
          fit_hit_next           = 1'b1;
        end
      end else if (b_eval.foot_dist < nofit_best_distance) begin
        nofit_best_distance_next = b_eval.foot_dist;
        nofit_best_index_next    = gap_position;
        nofit_found_next         = 1'b1;
      end
    end
  end

  // final pick for a list ending with this gap
  always_comb begin
    res_valid = 1'b0;
    res_idx   = '0;
    res_rule  = bfgs_pkg::RULE_CONTAIN;
    if (contain_found_next) begin
      res_valid = 1'b1;
      res_idx   = contain_index_next;
      res_rule  = bfgs_pkg::RULE_CONTAIN;
    end else if (fit_tally_next == bfgs_pkg::TALLY_ONE) begin
      res_valid = 1'b1;
      res_idx   = fit_recent_index_next;
      res_rule  = bfgs_pkg::RULE_ONLY_FIT;
    end else if (fit_tally_next == bfgs_pkg::TALLY_MANY) begin
      // only counts if some fitting gap beat the start distance
      if (fit_hit_next) begin
        res_valid = 1'b1;
        res_idx   = fit_best_index_next;
        res_rule  = bfgs_pkg::RULE_BEST_FIT;
      end
    end else if (nofit_found_next) begin
      res_valid = 1'b1;
      res_idx   = nofit_best_index_next;
      res_rule  = bfgs_pkg::RULE_BEST_MISS;
    end
    // one-gap list always returns its gap
    if (gap_position == '0) begin
      res_valid = 1'b1;
      res_idx   = '0;
      if (!contain_found_next && fit_tally_next == bfgs_pkg::TALLY_NONE) begin
        res_rule = bfgs_pkg::RULE_BEST_MISS;
      end
    end
    if (!res_valid) begin
      res_idx  = '0;
      res_rule = bfgs_pkg::RULE_CONTAIN;
    end
  end

  assign idx_ext = {5'b0, res_idx};

  always_ff @(posedge clk) begin
    if (rst || (b_go && b_last)) begin
      gap_position        <= '0;
      contain_found       <= 1'b0;
      contain_index       <= '0;
      fit_tally           <= bfgs_pkg::TALLY_NONE;
      fit_recent_index    <= '0;
      fit_best_index      <= '0;
      fit_best_distance   <= bfgs_pkg::DIST_START;
      fit_hit             <= 1'b0;
      nofit_best_index    <= '0;
      nofit_best_distance <= bfgs_pkg::DIST_START;
      nofit_found         <= 1'b0;
    end else if (b_go) begin
      if (gap_position != POS_MAX) begin
        gap_position <= gap_position + 1'b1;
      end
      contain_found       <= contain_found_next;
      contain_index       <= contain_index_next;
      fit_tally           <= fit_tally_next;
      fit_recent_index    <= fit_recent_index_next;
      fit_best_index      <= fit_best_index_next;
      fit_best_distance   <= fit_best_distance_next;
      fit_hit             <= fit_hit_next;
      nofit_best_index    <= nofit_best_index_next;
      nofit_best_distance <= nofit_best_distance_next;
      nofit_found         <= nofit_found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go && b_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_last) begin
      chosen_index <= idx_ext[bfgs_pkg::INDEX_W-1:0];
      chosen_valid <= res_valid;
      choice_rule  <= res_rule;
    end
  end

  `BFGS_ASSERT(a_last_gives_beat, b_go && b_last |=> out_valid, "last gap produced no result beat")
  `BFGS_ASSERT(a_list_cleared, b_go && b_last |=> gap_position == '0 && !contain_found && fit_tally == bfgs_pkg::TALLY_NONE && !nofit_found, "list state not cleared after last gap")
  `BFGS_ASSERT(a_contain_sticks, contain_found && !(b_go && b_last) |=> contain_found, "containing gap lost within a list")
  `BFGS_ASSERT(a_no_pick_zero, out_valid && !chosen_valid |-> chosen_index == '0 && choice_rule == bfgs_pkg::RULE_CONTAIN, "empty pick with nonzero index or rule")
  `BFGS_ASSERT_ALWAYS(a_tally_range, fit_tally !== 2'd3, "fit tally past saturation")

endmodule

// File: verif/tb_best_fit_gap_select.sv
// self-checking testbench for the best-fit gap selector
`timescale 1ns / 1ps

module tb_best_fit_gap_select;

  localparam int GAP_SLOTS   = 32;
  localparam int ITEM_TARGET = 1950;
  localparam logic signed [bfgs_pkg::FIELD_W-1:0] U        = 32'sd65536;
  localparam logic signed [bfgs_pkg::FIELD_W-1:0] MOST_NEG = 32'sh80000000;
  localparam logic signed [bfgs_pkg::FIELD_W-1:0] MOST_POS = 32'sh7fffffff;

  typedef struct packed {
    logic [bfgs_pkg::INDEX_W-1:0] idx;
    logic                         hit;
    bfgs_pkg::rule_t              rule;
  } choice_t;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [bfgs_pkg::FIELD_W-1:0] gap_bottom;
  logic signed [bfgs_pkg::FIELD_W-1:0] gap_top;
  logic signed [bfgs_pkg::FIELD_W-1:0] foot_z;
  logic signed [bfgs_pkg::FIELD_W-1:0] head_z;
  logic                                last_gap;
  logic                                out_valid;
  logic                                out_stall;
  logic [bfgs_pkg::INDEX_W-1:0]        chosen_index;
  logic                                chosen_valid;
  bfgs_pkg::rule_t                     choice_rule;

  // predicted list state
  logic [bfgs_pkg::INDEX_W-1:0] slot;
  logic                         contain_hit;
  logic [bfgs_pkg::INDEX_W-1:0] contain_pos;
  bfgs_pkg::tally_t             fit_count;
  logic [bfgs_pkg::INDEX_W-1:0] fit_last_pos;
  logic [bfgs_pkg::INDEX_W-1:0] fit_near_pos;
  bfgs_pkg::dist_t              fit_near_dist;
  logic [bfgs_pkg::INDEX_W-1:0] miss_near_pos;
  bfgs_pkg::dist_t              miss_near_dist;
  logic                         miss_seen;

  choice_t expected_choices[$];
  choice_t oldest_choice;

  int gaps_sent;
  int lists_sent;
  int choices_checked;
  int mismatch_count;
  int rules_seen[4];
  int src_idle_pct;
  int sink_stall_pct;
  int hold_cycles;
  int stall_left;

  best_fit_gap_select #(.MAX_GAPS(GAP_SLOTS)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .gap_bottom   (gap_bottom),
    .gap_top      (gap_top),
    .foot_z       (foot_z),
    .head_z       (head_z),
    .last_gap     (last_gap),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_index (chosen_index),
    .chosen_valid (chosen_valid),
    .choice_rule  (choice_rule)
  );

  always #5 clk = ~clk;

  function void clear_list_state();
    slot           = '0;
    contain_hit    = 1'b0;
    contain_pos    = '0;
    fit_count      = bfgs_pkg::TALLY_NONE;
    fit_last_pos   = '0;
    fit_near_pos   = '0;
    fit_near_dist  = bfgs_pkg::DIST_START;
    miss_near_pos  = '0;
    miss_near_dist = bfgs_pkg::DIST_START;
    miss_seen      = 1'b0;
  endfunction

  // runs one gap through the selection rules, queues a choice on the last gap
  function void predict_gap(input logic signed [bfgs_pkg::FIELD_W-1:0] f, c, z1, z2,
                            input logic last);
    logic signed [bfgs_pkg::DIST_W-1:0] fe, ce, z1e, z2e, d;
    logic                               lone;
    choice_t                            res;
    fe   = f;
    ce   = c;
    z1e  = z1;
    z2e  = z2;
    lone = last && (slot == 0);
    d    = z1e - fe;
    if (d < 0) d = -d;

    if (!contain_hit) begin
      if (z1 >= f && z2 <= c) begin
        contain_hit = 1'b1;
        contain_pos = slot;
      end else if (z2e - z1e <= ce - fe) begin
        if (fit_count != bfgs_pkg::TALLY_MANY) fit_count = fit_count + 1'b1;
        fit_last_pos = slot;
        if (bfgs_pkg::dist_t'(d) < fit_near_dist) begin
          fit_near_dist = bfgs_pkg::dist_t'(d);
          fit_near_pos  = slot;
        end
      end else if (bfgs_pkg::dist_t'(d) < miss_near_dist) begin
        miss_near_dist = bfgs_pkg::dist_t'(d);
        miss_near_pos  = slot;
        miss_seen      = 1'b1;
      end
    end

    if (!last) begin
      if (slot < GAP_SLOTS - 1) slot = slot + 1'b1;
      return;
    end

    res.idx  = '0;
    res.hit  = 1'b0;
    res.rule = bfgs_pkg::RULE_CONTAIN;
    if (contain_hit) begin
      res.idx = contain_pos; res.hit = 1'b1; res.rule = bfgs_pkg::RULE_CONTAIN;
    end else if (fit_count == bfgs_pkg::TALLY_ONE) begin
      res.idx = fit_last_pos; res.hit = 1'b1; res.rule = bfgs_pkg::RULE_ONLY_FIT;
    end else if (fit_count == bfgs_pkg::TALLY_MANY) begin
      // a closest fit only counts if it beat the start distance
      if (fit_near_dist < bfgs_pkg::DIST_START) begin
        res.idx = fit_near_pos; res.hit = 1'b1; res.rule = bfgs_pkg::RULE_BEST_FIT;
      end
    end else if (miss_seen) begin
      res.idx = miss_near_pos; res.hit = 1'b1; res.rule = bfgs_pkg::RULE_BEST_MISS;
    end
    // a one-gap list always returns its gap
    if (lone) begin
      res.idx = '0;
      res.hit = 1'b1;
      if (!contain_hit && fit_count == bfgs_pkg::TALLY_NONE) begin
        res.rule = bfgs_pkg::RULE_BEST_MISS;
      end
    end
    if (!res.hit) begin
      res.idx  = '0;
      res.rule = bfgs_pkg::RULE_CONTAIN;
    end
    expected_choices.push_back(res);
    rules_seen[res.rule]++;
    clear_list_state();
  endfunction

  // input beats feed the prediction, output beats are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_choices.size() == 0) begin
          $display("%0t: unexpected result, index %0d valid %0b rule %0d",
                   $time, chosen_index, chosen_valid, choice_rule);
          mismatch_count++;
        end else begin
          oldest_choice = expected_choices.pop_front();
          if (chosen_index !== oldest_choice.idx) begin
            $display("%0t: chosen_index expected %0d got %0d",
                     $time, oldest_choice.idx, chosen_index);
            mismatch_count++;
          end
          if (chosen_valid !== oldest_choice.hit) begin
            $display("%0t: chosen_valid expected %0b got %0b",
                     $time, oldest_choice.hit, chosen_valid);
            mismatch_count++;
          end
          if (choice_rule !== oldest_choice.rule) begin
            $display("%0t: choice_rule expected %0d got %0d",
                     $time, oldest_choice.rule, choice_rule);
            mismatch_count++;
          end
          choices_checked++;
        end
      end
      if (in_valid && !in_stall)
        predict_gap(gap_bottom, gap_top, foot_z, head_z, last_gap);
    end
  end

  // mostly short pauses, a few long ones
  function int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  function int list_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(13, 36);
  endfunction

  // result side: random stalls plus a requested long hold-off
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        out_stall  = 1'b1;
        stall_left = pick_len() - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_gap(input logic signed [bfgs_pkg::FIELD_W-1:0] bot, top, foot, head,
                          input logic last);
    gap_bottom = bot;
    gap_top    = top;
    foot_z     = foot;
    head_z     = head;
    last_gap   = last;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    gaps_sent++;
    if (last) lists_sent++;
    @(negedge clk);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid = 1'b0;
      repeat (pick_len()) @(negedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (expected_choices.size() != 0) @(posedge clk);
    // idle before the next test
    repeat (4) @(negedge clk);
  endtask

  task automatic send_random_list(input int len);
    logic signed [bfgs_pkg::FIELD_W-1:0] foot, head, bot, top;
    int                                  unit;
    int                                  contain_at;
    bit                                  drift;
    unit = ($urandom_range(0, 3) == 0) ? 1 : 65536;
    if ($urandom_range(0, 19) == 0) begin
      foot = $urandom;
      head = $urandom;
    end else begin
      foot = (int'($urandom_range(0, 400)) - 200) * unit;
      head = foot + (int'($urandom_range(0, 24)) - 2) * unit;
    end
    // foot and head wandering inside a list is a broken sequence
    drift      = ($urandom_range(0, 19) == 0);
    contain_at = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, len - 1)) : -1;
    for (int i = 0; i < len; i++) begin
      if (drift) begin
        foot = foot + (int'($urandom_range(0, 6)) - 3) * unit;
        if ($urandom_range(0, 1)) head = $urandom;
      end
      if (i == contain_at) begin
        bot = foot - int'($urandom_range(0, 3)) * unit;
        top = head + int'($urandom_range(0, 3)) * unit;
      end else if ($urandom_range(0, 9) == 0) begin
        bot = $urandom;
        top = $urandom;
      end else begin
        bot = foot + (int'($urandom_range(0, 12)) - 6) * unit;
        top = bot + (head - foot) + (int'($urandom_range(0, 6)) - 3) * unit;
      end
      send_gap(bot, top, foot, head, i == len - 1);
    end
  endtask

  task automatic test_directed_cases();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // one-gap lists: contains, fits only, neither
    send_gap(0, 10 * U, 2 * U, 5 * U, 1'b1);
    send_gap(0, 10 * U, 20 * U, 25 * U, 1'b1);
    send_gap(0, 1 * U, 0, 5 * U, 1'b1);
    // field extremes
    send_gap(MOST_NEG, MOST_POS, MOST_POS, MOST_NEG, 1'b1);
    send_gap(MOST_POS, MOST_NEG, MOST_NEG, MOST_POS, 1'b1);
    // gaps after a containing one change nothing
    send_gap(30 * U, 31 * U, 0, 5 * U, 1'b0);
    send_gap(-1 * U, 6 * U, 0, 5 * U, 1'b0);
    send_gap(0, 5 * U, 0, 5 * U, 1'b1);
    // a single tall-enough gap behind a miss
    send_gap(3 * U, 4 * U, 0, 5 * U, 1'b0);
    send_gap(8 * U, 20 * U, 0, 5 * U, 1'b1);
    // closest fit, tie goes to the earlier gap
    send_gap(4 * U, 20 * U, 0, 5 * U, 1'b0);
    send_gap(2 * U, 20 * U, 0, 5 * U, 1'b0);
    send_gap(-2 * U, 3 * U + 32'sd7, 0, 5 * U + 32'sd7, 1'b1);
    // closest miss, tie to the earlier gap
    send_gap(5 * U, 6 * U, 0, 5 * U, 1'b0);
    send_gap(2 * U, 3 * U, 0, 5 * U, 1'b0);
    send_gap(-2 * U, -1 * U, 0, 5 * U, 1'b1);
    // inverted gap and inverted object
    send_gap(10 * U, 5 * U, 7 * U, 6 * U, 1'b1);
    wait_drain();
  endtask

  task automatic test_long_lists();
    int lens[5];
    lens = '{31, 32, 33, 45, 70};
    src_idle_pct   = 20;
    sink_stall_pct = 20;
    foreach (lens[k]) send_random_list(lens[k]);
    wait_drain();
  endtask

  task automatic test_output_hold_off();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_cycles    = 250;
    repeat (30) send_random_list($urandom_range(1, 3));
    wait_drain();
  endtask

  task automatic test_drain_pauses();
    src_idle_pct   = 25;
    sink_stall_pct = 25;
    repeat (3) begin
      repeat (5) send_random_list(list_len());
      wait_drain();
    end
  endtask

  task automatic test_random_lists();
    while (gaps_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 25; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 40; end
        default: begin src_idle_pct = 30; sink_stall_pct = 30; end
      endcase
      repeat (25) send_random_list(list_len());
    end
    wait_drain();
  endtask

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    in_valid        = 1'b0;
    gap_bottom      = '0;
    gap_top         = '0;
    foot_z          = '0;
    head_z          = '0;
    last_gap        = 1'b0;
    gaps_sent       = 0;
    lists_sent      = 0;
    choices_checked = 0;
    mismatch_count  = 0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_cycles     = 0;
    foreach (rules_seen[k]) rules_seen[k] = 0;
    clear_list_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_long_lists();
    test_output_hold_off();
    test_drain_pauses();
    test_random_lists();

    if (expected_choices.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_choices.size());
      mismatch_count++;
    end
    $display("%0d gaps in %0d lists, %0d choices checked, %0d mismatches",
             gaps_sent, lists_sent, choices_checked, mismatch_count);
    $display("rules picked: contain %0d, only fit %0d, closest fit %0d, closest miss %0d",
             rules_seen[bfgs_pkg::RULE_CONTAIN], rules_seen[bfgs_pkg::RULE_ONLY_FIT],
             rules_seen[bfgs_pkg::RULE_BEST_FIT], rules_seen[bfgs_pkg::RULE_BEST_MISS]);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results still expected", $time, expected_choices.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
